// ===== hdl/aes_block_cipher_assert.svh =====
// Assertion macros used by the checker in aes_checker.sv
`ifndef AES_BLOCK_CIPHER_ASSERT_SVH
`define AES_BLOCK_CIPHER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define AES_ASSERT_NOW(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AES_ASSERT_NEXT(lbl, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) else $error(msg);

`endif

// ===== hdl/aes_pkg.sv =====
`timescale 1ns / 1ps

package aes_pkg;

  localparam int BLOCK_BITS = 128;
  localparam int HALF_BITS  = 64;
  localparam int WORD_BITS  = 32;
  localparam int KEY_BITS   = 256;
  localparam int STEP_BITS  = 4;   // round number, up to 14
  localparam int CFG_IDX_BITS = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_WORD0  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_WORD1  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_WORD2  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_WORD3  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_KEY_LENGTH = 3'd4;

  // key length codes
  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;
  localparam logic [1:0] KLEN_256 = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_PRIME,
    ST_ROUND,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic decrypt;
    logic first;   // initial key addition only
    logic last;    // no column mix
  } round_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
    8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
    8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
    8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
    8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
    8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
    8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
    8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
    8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
    8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
    8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
    8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
    8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
    8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
    8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
    8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
    8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
    8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
    8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
    8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
    8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
    8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
    8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
    8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
    8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
    8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
    8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
    8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
    8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
    8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
  };

  // multiply by x modulo x^8+x^4+x^3+x+1
  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // one column of MixColumns or InvMixColumns, byte 0 in bits 7:0
  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] r;
    for (int k = 0; k < 4; k++) begin
      a[k]  = c[8*k +: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    for (int j = 0; j < 4; j++) begin
      if (inv) begin
        r[8*j +: 8] = me[j] ^ mb[(j+1)%4] ^ md[(j+2)%4] ^ m9[(j+3)%4];
      end else begin
        r[8*j +: 8] = x2[j] ^ x2[(j+1)%4] ^ a[(j+1)%4] ^ a[(j+2)%4] ^ a[(j+3)%4];
      end
    end
    return r;
  endfunction

  // ShiftRows / InvShiftRows on bytes 4*col+row
  function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
    logic [127:0] t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (inv) begin
          t[8*(4*((c+r)%4)+r) +: 8] = s[8*(4*c+r) +: 8];
        end else begin
          t[8*(4*c+r) +: 8] = s[8*(4*((c+r)%4)+r) +: 8];
        end
      end
    end
    return t;
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    logic [31:0] r;
    for (int k = 0; k < 4; k++) begin
      r[8*k +: 8] = SBOX[w[8*k +: 8]];
    end
    return r;
  endfunction

endpackage

// ===== hdl/aes_ram.sv =====
`timescale 1ns / 1ps

module aes_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 15
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/aes_key_step.sv =====
`timescale 1ns / 1ps

module aes_key_step (
  input  logic [5:0]                   kidx,
  input  logic [3:0]                   nk,
  input  logic [2:0]                   kmod,
  input  logic [7:0]                   rcon,
  input  logic [aes_pkg::KEY_BITS-1:0] win,
  input  logic [aes_pkg::KEY_BITS-1:0] key,
  output logic [aes_pkg::WORD_BITS-1:0] word
);
  import aes_pkg::*;

  logic [WORD_BITS-1:0] prev;
  logic [WORD_BITS-1:0] far;
  logic [WORD_BITS-1:0] t;

  // win holds the last eight words, newest in bits 31:0
  assign prev = win[31:0];

  always_comb begin
    case (nk)
      4'd4:    far = win[127:96];
      4'd6:    far = win[191:160];
      default: far = win[255:224];
    endcase
  end

  // one expanded key word per cycle
  always_comb begin
    t = prev;
    if (kmod == 3'd0) begin
      t = sub_word({prev[7:0], prev[31:8]}) ^ {24'h0, rcon};
    end else if (nk == 4'd8 && kmod == 3'd4) begin
      t = sub_word(prev);
    end
    if (kidx < {2'b00, nk}) begin
      word = key[32*kidx[2:0] +: 32];
    end else begin
      word = far ^ t;
    end
  end

endmodule

// ===== hdl/aes_round.sv =====
`timescale 1ns / 1ps

module aes_round (
  input  logic [aes_pkg::BLOCK_BITS-1:0] st,
  input  logic [aes_pkg::BLOCK_BITS-1:0] rk,
  input  aes_pkg::round_ctrl_t           ctrl,
  output logic [aes_pkg::BLOCK_BITS-1:0] st_out
);
  import aes_pkg::*;

  logic [BLOCK_BITS-1:0] sub_s;
  logic [BLOCK_BITS-1:0] shf_s;
  logic [BLOCK_BITS-1:0] mix_s;
  logic [BLOCK_BITS-1:0] isub_s;
  logic [BLOCK_BITS-1:0] ishf_s;
  logic [BLOCK_BITS-1:0] iadd_s;
  logic [BLOCK_BITS-1:0] imix_s;

  // forward round: SubBytes, ShiftRows, MixColumns
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sub_s[8*i +: 8] = SBOX[st[8*i +: 8]];
    end
    shf_s = shift_rows(sub_s, 1'b0);
    for (int c = 0; c < 4; c++) begin
      mix_s[32*c +: 32] = mix_col(shf_s[32*c +: 32], 1'b0);
    end
  end

  // inverse round: InvShiftRows, InvSubBytes, key, InvMixColumns
  always_comb begin
    ishf_s = shift_rows(st, 1'b1);
    for (int i = 0; i < 16; i++) begin
      isub_s[8*i +: 8] = INV_SBOX[ishf_s[8*i +: 8]];
    end
    iadd_s = isub_s ^ rk;
    for (int c = 0; c < 4; c++) begin
      imix_s[32*c +: 32] = mix_col(iadd_s[32*c +: 32], 1'b1);
    end
  end

  always_comb begin
    if (ctrl.first) begin
      st_out = st ^ rk;
    end else if (ctrl.decrypt) begin
      st_out = ctrl.last ? iadd_s : imix_s;
    end else begin
      st_out = (ctrl.last ? shf_s : mix_s) ^ rk;
    end
  end

endmodule

// ===== hdl/aes_block_cipher.sv =====
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    in_kind, in_block_low, in_block_high
// out      output     out_valid/out_stall  out_data_low, out_data_high
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A block takes one round per cycle through the shared round unit, plus a round
// key read ahead and the initial key addition. The first request after a key
// or key-length write, or after reset, first expands the key, one 32-bit word a
// cycle (44, 52 or 60 words). in_stall is high while a block is in work;
// a finished block waits in the core if out_stall holds the output register.
// rst_n is synchronous; the round key store is not cleared.

module aes_block_cipher #(
  parameter int ROUND_KEY_WORDS = 30
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic [aes_pkg::HALF_BITS-1:0]      in_block_low,
  input  logic [aes_pkg::HALF_BITS-1:0]      in_block_high,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [aes_pkg::HALF_BITS-1:0]      out_data_low,
  output logic [aes_pkg::HALF_BITS-1:0]      out_data_high,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aes_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [aes_pkg::HALF_BITS-1:0]      cfg_data
);
  import aes_pkg::*;

  localparam int RAM_DEPTH = (ROUND_KEY_WORDS + 1) / 2;
  localparam int AW        = $clog2(RAM_DEPTH);
  localparam bit FIT_256   = ROUND_KEY_WORDS >= 30;
  localparam bit FIT_192   = ROUND_KEY_WORDS >= 26;

  state_t state_r, state_nxt;

  logic [HALF_BITS-1:0]  key0_r, key1_r, key2_r, key3_r;
  logic [1:0]            klen_r;
  logic                  keys_ready_r, keys_ready_nxt;
  logic [STEP_BITS-1:0]  nr_r, nr_nxt;
  logic [STEP_BITS-1:0]  step_r, step_nxt;
  logic [5:0]            kidx_r, kidx_nxt;
  logic [2:0]            kmod_r, kmod_nxt;
  logic [7:0]            rcon_r, rcon_nxt;
  logic [KEY_BITS-1:0]   win_r, win_nxt;
  logic                  dec_r, dec_nxt;
  logic [BLOCK_BITS-1:0] st_r, st_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [BLOCK_BITS-1:0] out_r, out_nxt;

  logic [1:0]            len_eff;
  logic [3:0]            nk_c;
  logic [STEP_BITS-1:0]  nr_c;
  logic [5:0]            total_m1;
  logic [3:0]            nk_cur;
  logic [WORD_BITS-1:0]  key_word;
  logic                  in_acc, cfg_acc, out_free;
  logic [STEP_BITS-1:0]  rd_step, rd_round;
  logic [HALF_BITS-1:0]  rk_even, rk_odd;
  logic [BLOCK_BITS-1:0] round_out;
  round_ctrl_t           ctrl;

  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE);
  // no register write in the cycle a request is offered
  assign cfg_ready = (state_r == ST_IDLE) && !in_valid;
  assign out_free  = !out_valid_r || !out_stall;

  // effective key length: code 3 as 256 bit, shortened to what the store holds
  always_comb begin
    len_eff = (klen_r == 2'd3) ? KLEN_256 : klen_r;
    if (len_eff == KLEN_256 && !FIT_256) begin
      len_eff = FIT_192 ? KLEN_192 : KLEN_128;
    end
    if (len_eff == KLEN_192 && !FIT_192) begin
      len_eff = KLEN_128;
    end
    nk_c = 4'd4 + {1'b0, len_eff, 1'b0};
    nr_c = 4'd10 + {1'b0, len_eff, 1'b0};
  end

  // nk and word count follow the rounds latched at expansion
  assign nk_cur   = nr_r - 4'd6;
  assign total_m1 = {nr_r, 2'b11};

  aes_key_step u_key_step (
    .kidx (kidx_r),
    .nk   (nk_cur),
    .kmod (kmod_r),
    .rcon (rcon_r),
    .win  (win_r),
    .key  ({key3_r, key2_r, key1_r, key0_r}),
    .word (key_word)
  );

  // round key store: even and odd 64-bit words of each round
  logic we_even, we_odd;
  logic [AW-1:0] waddr, raddr;

  assign we_even = (state_r == ST_EXPAND) && kidx_r[0] && !kidx_r[1];
  assign we_odd  = (state_r == ST_EXPAND) && kidx_r[0] && kidx_r[1];
  assign waddr   = kidx_r[AW+1:2];

  assign rd_step  = (state_r == ST_PRIME) ? step_r : step_r + 4'd1;
  assign rd_round = dec_r ? nr_r - rd_step : rd_step;
  assign raddr    = rd_round[AW-1:0];

  aes_ram #(.WIDTH(HALF_BITS), .DEPTH(RAM_DEPTH)) u_rk_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (waddr),
    .wdata ({key_word, win_r[31:0]}),
    .raddr (raddr),
    .rdata (rk_even)
  );

  aes_ram #(.WIDTH(HALF_BITS), .DEPTH(RAM_DEPTH)) u_rk_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (waddr),
    .wdata ({key_word, win_r[31:0]}),
    .raddr (raddr),
    .rdata (rk_odd)
  );

  // shared round unit
  assign ctrl.decrypt = dec_r;
  assign ctrl.first   = (step_r == '0);
  assign ctrl.last    = (step_r == nr_r);

  aes_round u_round (
    .st     (st_r),
    .rk     ({rk_odd, rk_even}),
    .ctrl   (ctrl),
    .st_out (round_out)
  );

  // key registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r <= '0;
      key1_r <= '0;
      key2_r <= '0;
      key3_r <= '0;
      klen_r <= KLEN_128;
    end else if (cfg_acc) begin
      case (cfg_index)
        CFG_KEY_WORD0:  key0_r <= cfg_data;
        CFG_KEY_WORD1:  key1_r <= cfg_data;
        CFG_KEY_WORD2:  key2_r <= cfg_data;
        CFG_KEY_WORD3:  key3_r <= cfg_data;
        CFG_KEY_LENGTH: klen_r <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // sequencer: next state and datapath control
  always_comb begin
    state_nxt      = state_r;
    keys_ready_nxt = keys_ready_r;
    nr_nxt         = nr_r;
    step_nxt       = step_r;
    kidx_nxt       = kidx_r;
    kmod_nxt       = kmod_r;
    rcon_nxt       = rcon_r;
    win_nxt        = win_r;
    dec_nxt        = dec_r;
    st_nxt         = st_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;

    if (cfg_acc && cfg_index <= CFG_KEY_LENGTH) begin
      keys_ready_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt   = {in_block_high, in_block_low};
          dec_nxt  = in_kind;
          step_nxt = '0;
          if (keys_ready_r) begin
            state_nxt = ST_PRIME;
          end else begin
            state_nxt = ST_EXPAND;
            nr_nxt    = nr_c;
            kidx_nxt  = '0;
            kmod_nxt  = '0;
            rcon_nxt  = 8'h01;
          end
        end
      end
      ST_EXPAND: begin
        win_nxt  = {win_r[KEY_BITS-WORD_BITS-1:0], key_word};
        kidx_nxt = kidx_r + 6'd1;
        kmod_nxt = ({1'b0, kmod_r} == nk_cur - 4'd1) ? 3'd0 : kmod_r + 3'd1;
        if (kidx_r >= {2'b00, nk_cur} && kmod_r == 3'd0) begin
          rcon_nxt = xtime(rcon_r);
        end
        if (kidx_r == total_m1) begin
          keys_ready_nxt = 1'b1;
          state_nxt      = ST_PRIME;
        end
      end
      ST_PRIME: begin
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        st_nxt   = round_out;
        step_nxt = step_r + 4'd1;
        if (ctrl.last) begin
          if (out_free) begin
            out_nxt       = round_out;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_nxt       = st_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      keys_ready_r <= 1'b0;
      out_valid_r  <= 1'b0;
      nr_r         <= 4'd10;
      step_r       <= '0;
      kidx_r       <= '0;
      kmod_r       <= '0;
      rcon_r       <= 8'h01;
    end else begin
      state_r      <= state_nxt;
      keys_ready_r <= keys_ready_nxt;
      out_valid_r  <= out_valid_nxt;
      nr_r         <= nr_nxt;
      step_r       <= step_nxt;
      kidx_r       <= kidx_nxt;
      kmod_r       <= kmod_nxt;
      rcon_r       <= rcon_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    win_r <= win_nxt;
    dec_r <= dec_nxt;
    st_r  <= st_nxt;
    out_r <= out_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_data_low  = out_r[HALF_BITS-1:0];
  assign out_data_high = out_r[BLOCK_BITS-1:HALF_BITS];

endmodule

// ===== hdl/aes_checker.sv =====
`timescale 1ns / 1ps

`include "aes_block_cipher_assert.svh"

module aes_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_kind,
  input logic [aes_pkg::HALF_BITS-1:0]    in_block_low,
  input logic [aes_pkg::HALF_BITS-1:0]    in_block_high,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [aes_pkg::HALF_BITS-1:0]    out_data_low,
  input logic [aes_pkg::HALF_BITS-1:0]    out_data_high,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [aes_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input logic [aes_pkg::HALF_BITS-1:0]    cfg_data
);

  // a held result keeps its valid
  `AES_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped while stalled")

  // a request occupies the core: no second one the next cycle
  `AES_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall, "input taken on back-to-back cycles")

  // no result can appear in the cycle after a request
  `AES_ASSERT_NEXT(a_no_instant_result, in_valid && !in_stall, !$rose(out_valid), "result too early")

  // config writes only while no request is in work
  `AES_ASSERT_NOW(a_cfg_idle, cfg_ready, !in_stall, "config ready while busy")

endmodule

bind aes_block_cipher aes_checker u_aes_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .in_kind       (in_kind),
  .in_block_low  (in_block_low),
  .in_block_high (in_block_high),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_data_low  (out_data_low),
  .out_data_high (out_data_high),
  .cfg_valid     (cfg_valid),
  .cfg_ready     (cfg_ready),
  .cfg_index     (cfg_index),
  .cfg_data      (cfg_data)
);
